/* rtl/bpc_pkg.sv */
// Shared types and constants for the barometric compensation datapath.
// Used by the front pipeline, the item queue, the back pipeline and the top level.
package bpc_pkg;

  // Configuration register indexes.
  localparam int unsigned IDXW = 3;
  localparam logic [IDXW-1:0] REG_TEMP       = 3'd0;
  localparam logic [IDXW-1:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [IDXW-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [IDXW-1:0] REG_PRESS_NINE = 3'd3;

  // Datapath widths between the front and back halves.
  localparam int unsigned NMW  = 110;  // scaled pressure numerator
  localparam int unsigned DENW = 74;   // pressure divisor
  localparam int unsigned QW   = 42;   // intermediate pressure magnitude
  localparam int unsigned ZW   = 102;  // final pressure polynomial
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPW  = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  // One sample after the front half: temperature results plus the division operands.
  typedef struct packed {
    logic [20:0]     fine;
    logic [15:0]     centi;
    logic [NMW-1:0]  nm;
    logic [DENW-1:0] den;
    logic            qneg;
    logic            fault;
  } item_t;

endpackage

/* rtl/bpc_front.sv */
// Front pipeline: accepts samples, computes the fine temperature and the
// pressure division operands. Depends on bpc_pkg.
module bpc_front (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::coef_t    coef,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [19:0]       raw_pressure,
  input  logic [19:0]       raw_temperature,
  input  logic              queue_full,
  output logic              push,
  output bpc_pkg::item_t    item
);

  localparam int unsigned NST = 13;
  localparam int unsigned SW  = 62;

  logic [NST-1:0] vld;
  logic           adv;

  logic [19:0]        rp [1:9];
  logic signed [20:0] fine [5:12];
  logic [15:0]        centi [6:12];

  logic signed [21:0] d1;
  logic signed [37:0] dt2_2, dt2_3;
  logic signed [43:0] dd2;
  logic signed [59:0] dt3_3;
  logic signed [SW-1:0] s4;
  logic signed [21:0] a6;
  logic signed [43:0] aa7;
  logic signed [37:0] ap5_7, ap2_7, ap5_8, ap2_8;
  logic signed [59:0] aap6_8, aap3_8;
  logic signed [61:0] x9, y9, y10;
  logic signed [62:0] num10;
  logic [56:0]        nmag11, ymag11;
  logic               qneg11, yzero11, qneg12, fault12;
  logic [69:0]        n6250_12;
  logic [44:0]        dlo12;
  logic [43:0]        dhi12;
  bpc_pkg::item_t     item13;

  logic signed [21:0]   d_next;
  logic signed [20:0]   fine_next;
  logic [15:0]          centi_next;
  logic signed [21:0]   a_next;
  logic signed [62:0]   num_next;

  assign adv          = !(vld[NST-1] && queue_full);
  assign sample_stall = !adv;
  assign push         = vld[NST-1] && !queue_full;
  assign item         = item13;

  always_comb begin
    logic signed [SW-1:0] s_adj;
    logic signed [SW-1:0] fw;
    logic signed [23:0]   f5;
    logic signed [23:0]   c;
    logic [20:0]          pr;
    d_next = $signed({2'b00, raw_temperature}) - $signed({2'b00, coef.t1, 4'b0000});
    // Division by 2^34 truncating toward zero.
    s_adj = s4 + $signed({{(SW-34){1'b0}}, {34{s4[SW-1]}}});
    fw    = s_adj >>> 34;
    if (fw > 62'sd1048575) begin
      fine_next = 21'sd1048575;
    end else if (fw < -62'sd1048576) begin
      fine_next = -21'sd1048576;
    end else begin
      fine_next = fw[20:0];
    end
    f5 = (24'(fine[5]) <<< 2) + 24'(fine[5]);
    c  = (f5 + (f5[23] ? 24'sd255 : 24'sd0)) >>> 8;
    centi_next = c[15:0];
    a_next = 22'(fine[5]) - 22'sd128000;
    pr = 21'h100000 - {1'b0, rp[9]};
    num_next = ($signed({42'd0, pr}) <<< 31) - 63'(x9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], sample_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp[1] <= raw_pressure;
      for (int k = 2; k <= 9; k++) rp[k] <= rp[k-1];
      fine[5] <= fine_next;
      for (int k = 6; k <= 12; k++) fine[k] <= fine[k-1];
      centi[6] <= centi_next;
      for (int k = 7; k <= 12; k++) centi[k] <= centi[k-1];

      d1     <= d_next;
      dt2_2  <= d1 * $signed(coef.t2);
      dd2    <= d1 * d1;
      dt2_3  <= dt2_2;
      dt3_3  <= dd2 * $signed(coef.t3);
      s4     <= (SW'(dt2_3) <<< 20) + SW'(dt3_3);
      a6     <= a_next;
      aa7    <= a6 * a6;
      ap5_7  <= a6 * $signed(coef.p5);
      ap2_7  <= a6 * $signed(coef.p2);
      aap6_8 <= aa7 * $signed(coef.p6);
      aap3_8 <= aa7 * $signed(coef.p3);
      ap5_8  <= ap5_7;
      ap2_8  <= ap2_7;
      x9     <= 62'(aap6_8) + (62'(ap5_8) <<< 17) + (62'($signed(coef.p4)) <<< 35);
      y9     <= (62'sd1 <<< 55) + 62'(aap3_8) + (62'(ap2_8) <<< 20);
      num10  <= num_next;
      y10    <= y9;
      nmag11  <= num10[62] ? 57'(-num10) : num10[56:0];
      ymag11  <= y10[61] ? 57'(-y10) : y10[56:0];
      qneg11  <= num10[62] ^ y10[61];
      yzero11 <= (y10 == '0);
      n6250_12 <= 70'(nmag11) * 70'd6250;
      dlo12    <= 45'(coef.p1) * 45'(ymag11[28:0]);
      dhi12    <= 44'(coef.p1) * 44'(ymag11[56:29]);
      qneg12   <= qneg11;
      fault12  <= (coef.p1 == '0) || yzero11;
      item13.fine  <= fine[12];
      item13.centi <= centi[12];
      item13.nm    <= {n6250_12, 40'd0};
      item13.den   <= 74'({dhi12, 29'd0}) + 74'(dlo12);
      item13.qneg  <= qneg12;
      item13.fault <= fault12;
    end
  end

endmodule

/* rtl/bpc_queue.sv */
// Short queue that parts the front and back pipelines.
// Depends on bpc_pkg for the item type and depth.
module bpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpc_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output bpc_pkg::item_t rdata,
  output logic           nonempty
);

  bpc_pkg::item_t            slots [bpc_pkg::QUEUE_DEPTH];
  logic [bpc_pkg::QPW-1:0]   wr_ptr, rd_ptr;
  logic [bpc_pkg::QPW:0]     count;

  assign full     = (count == (bpc_pkg::QPW+1)'(bpc_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule

/* rtl/bpc_back.sv */
// Back pipeline: restoring divider, one quotient bit per stage, then the
// second-order pressure correction and output register. Depends on bpc_pkg.
module bpc_back (
  input  logic           clk,
  input  logic           rst,
  input  bpc_pkg::coef_t coef,
  input  bpc_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [20:0]    fine_temperature,
  output logic [15:0]    temperature_centi,
  output logic [31:0]    pressure_q8,
  output logic           divide_fault
);

  localparam int unsigned DN   = bpc_pkg::QW;
  localparam int unsigned DW   = bpc_pkg::DENW;
  localparam int unsigned NW   = bpc_pkg::NMW;
  localparam int unsigned ZW   = bpc_pkg::ZW;

  typedef struct packed {
    logic        ovf;
    logic        qneg;
    logic        fault;
    logic [20:0] fine;
    logic [15:0] centi;
  } side_t;

  logic          adv;
  logic [DN:0]   dv;
  logic [4:1]    pv;
  logic [DW-1:0] rem   [0:DN];
  logic [DW-1:0] den   [0:DN];
  logic [DN-1:0] qb    [0:DN];
  logic [DN-1:0] nmlo  [0:DN];
  side_t         side  [0:DN];
  side_t         side1, side2, side3, side4;
  side_t         side0_next;

  logic [DN-1:0]        qmag_c, qmag1;
  logic signed [58:0]   p9m1, p8m1;
  logic signed [73:0]   m0_2, m1_2, m2_2;
  logic signed [ZW-1:0] lin2, sq3, lins3, z4;
  logic [31:0]          press_next;

  assign adv = !result_valid || !result_stall;
  assign pop = adv && head_valid;

  always_comb begin
    side0_next.ovf   = {{(DW-(NW-DN)){1'b0}}, head.nm[NW-1:DN]} >= head.den;
    side0_next.qneg  = head.qneg;
    side0_next.fault = head.fault;
    side0_next.fine  = head.fine;
    side0_next.centi = head.centi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv           <= '0;
      pv           <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      dv           <= {dv[DN-1:0], head_valid};
      pv           <= {pv[3:1], dv[DN]};
      result_valid <= pv[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= {{(DW-(NW-DN)){1'b0}}, head.nm[NW-1:DN]};
      den[0]  <= head.den;
      qb[0]   <= '0;
      nmlo[0] <= head.nm[DN-1:0];
      side[0] <= side0_next;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < DN; k++) begin : g_div
    logic [DW:0] t, diff;
    logic        ge;
    assign t    = {rem[k], nmlo[k][DN-1-k]};
    assign ge   = t >= {1'b0, den[k]};
    assign diff = t - {1'b0, den[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        qb[k+1]   <= {qb[k][DN-2:0], ge};
        den[k+1]  <= den[k];
        nmlo[k+1] <= nmlo[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign qmag_c = side[DN].ovf ? '1 : qb[DN];

  always_comb begin
    press_next = z4[90:59];
    if (side4.fault || z4[ZW-1]) begin
      press_next = '0;
    end else if (|z4[ZW-2:91]) begin
      press_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qmag1 <= qmag_c;
      p9m1  <= $signed(coef.p9) * $signed({1'b0, qmag_c});
      p8m1  <= $signed(coef.p8) * $signed({1'b0, qmag_c});
      side1 <= side[DN];

      m0_2  <= p9m1 * $signed({1'b0, qmag1[13:0]});
      m1_2  <= p9m1 * $signed({1'b0, qmag1[27:14]});
      m2_2  <= p9m1 * $signed({1'b0, qmag1[41:28]});
      lin2  <= (ZW'($signed({1'b0, qmag1})) <<< 51) + (ZW'(p8m1) <<< 32);
      side2 <= side1;

      sq3   <= ZW'(m0_2) + (ZW'(m1_2) <<< 14) + (ZW'(m2_2) <<< 28);
      lins3 <= side2.qneg ? -lin2 : lin2;
      side3 <= side2;

      z4    <= sq3 + lins3 + (ZW'($signed(coef.p7)) <<< 63);
      side4 <= side3;

      fine_temperature  <= side4.fine;
      temperature_centi <= side4.centi;
      pressure_q8       <= press_next;
      divide_fault      <= side4.fault;
    end
  end

endmodule

/* rtl/barometric_pressure_compensation.sv */
// Barometric pressure compensation, fully pipelined: one sample per cycle
// while no stall holds it back. A sample passes 13 front stages, the queue,
// a load register, 42 divider stages and 5 more correction and output stages.
// The 42-stage restoring divider sets the depth; one result per unstalled cycle.
// Synchronous reset clears all valid state and sets every coefficient to zero.
module barometric_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [2:0]  write_index,
  input  logic [63:0] write_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [20:0] fine_temperature,
  output logic signed [15:0] temperature_centi,
  output logic [31:0] pressure_q8,
  output logic        divide_fault
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  bpc_pkg::coef_t coef;
  bpc_pkg::item_t front_item, head_item;
  logic           push, pop, queue_full, head_valid;
  logic [20:0]    fine_bits;
  logic [15:0]    centi_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (write_enable) begin
      case (write_index)
        bpc_pkg::REG_TEMP:       temp_coeffs       <= write_data[47:0];
        bpc_pkg::REG_PRESS_LOW:  press_coeffs_low  <= write_data;
        bpc_pkg::REG_PRESS_HIGH: press_coeffs_high <= write_data;
        bpc_pkg::REG_PRESS_NINE: press_coeff_nine  <= write_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = temp_coeffs[31:16];
    coef.t3 = temp_coeffs[47:32];
    coef.p1 = press_coeffs_low[15:0];
    coef.p2 = press_coeffs_low[31:16];
    coef.p3 = press_coeffs_low[47:32];
    coef.p4 = press_coeffs_low[63:48];
    coef.p5 = press_coeffs_high[15:0];
    coef.p6 = press_coeffs_high[31:16];
    coef.p7 = press_coeffs_high[47:32];
    coef.p8 = press_coeffs_high[63:48];
    coef.p9 = press_coeff_nine;
  end

  bpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .queue_full      (queue_full),
    .push            (push),
    .item            (front_item)
  );

  bpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_item),
    .full     (queue_full),
    .pop      (pop),
    .rdata    (head_item),
    .nonempty (head_valid)
  );

  bpc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .coef              (coef),
    .head              (head_item),
    .head_valid        (head_valid),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .fine_temperature  (fine_bits),
    .temperature_centi (centi_bits),
    .pressure_q8       (pressure_q8),
    .divide_fault      (divide_fault)
  );

  assign fine_temperature  = $signed(fine_bits);
  assign temperature_centi = $signed(centi_bits);

endmodule
